// ===== rtl/ledseq_pkg.sv =====
`default_nettype none

package ledseq_pkg;

    // Default parameter values and fixed field widths.
    localparam int GRAY_BITS_DEF   = 12;
    localparam int BRIGHT_BITS_DEF = 8;
    localparam int OP_W            = 3;
    localparam int VALUE_W         = 16;
    localparam int PIN_W           = 2;
    localparam int CNT_W           = 5;
    localparam int SEG_W           = 3;

    // Command codes.
    localparam logic [OP_W-1:0] OP_GRAY   = 3'd0;
    localparam logic [OP_W-1:0] OP_LATCH  = 3'd1;
    localparam logic [OP_W-1:0] OP_BRIGHT = 3'd2;
    localparam logic [OP_W-1:0] OP_INT    = 3'd3;
    localparam logic [OP_W-1:0] OP_EXT    = 3'd4;

    // Pin selects, matching the bit order of the per-chain pin levels.
    localparam logic [PIN_W-1:0] PIN_CLK  = 2'd0;
    localparam logic [PIN_W-1:0] PIN_DATA = 2'd1;
    localparam logic [PIN_W-1:0] PIN_LAT  = 2'd2;

    // Segment kinds of a command program.
    typedef enum logic [1:0] {
        SEG_SET   = 2'd0,
        SEG_PULSE = 2'd1,
        SEG_SHIFT = 2'd2
    } t_kind;

    // One program segment: a single pin write, a run of pulses or a bit shift.
    typedef struct packed {
        t_kind              kind;
        logic [PIN_W-1:0]   pin;
        logic               level;
        logic [CNT_W-1:0]   count;
        logic               last;
    } t_seg;

    // One pin step handed from the sequencer to the pin register stage.
    typedef struct packed {
        logic               ch;
        logic [PIN_W-1:0]   pin;
        logic               level;
        logic               last;
    } t_step;

    function automatic t_seg mk_seg(input t_kind kind, input logic [PIN_W-1:0] pin,
                                    input logic level, input logic [CNT_W-1:0] count,
                                    input logic last);
        t_seg s;
        s.kind  = kind;
        s.pin   = pin;
        s.level = level;
        s.count = count;
        s.last  = last;
        return s;
    endfunction

    function automatic t_seg set_seg(input logic [PIN_W-1:0] pin, input logic level,
                                     input logic last);
        return mk_seg(SEG_SET, pin, level, CNT_W'(1), last);
    endfunction

    // Command programs, indexed by command code and segment number.
    function automatic t_seg ledseq_seg(input logic [OP_W-1:0] op, input logic [SEG_W-1:0] idx,
                                        input int gray_bits, input int bright_bits);
        t_seg             s;
        logic [CNT_W-1:0] gb;
        logic [CNT_W-1:0] bb;
        gb = CNT_W'(gray_bits);
        bb = CNT_W'(bright_bits);
        s  = set_seg(PIN_CLK, 1'b0, 1'b1);
        unique case (op)
            OP_GRAY: begin
                unique case (idx)
                    3'd0:    s = mk_seg(SEG_SHIFT, PIN_DATA, 1'b0, gb, 1'b0);
                    3'd1:    s = set_seg(PIN_CLK, 1'b0, 1'b0);
                    default: s = set_seg(PIN_DATA, 1'b0, 1'b1);
                endcase
            end
            OP_LATCH: begin
                unique case (idx)
                    3'd0:    s = set_seg(PIN_CLK, 1'b0, 1'b0);
                    3'd1:    s = set_seg(PIN_LAT, 1'b1, 1'b0);
                    default: s = set_seg(PIN_LAT, 1'b0, 1'b1);
                endcase
            end
            OP_BRIGHT: begin
                unique case (idx)
                    3'd0:    s = set_seg(PIN_CLK, 1'b1, 1'b0);
                    3'd1:    s = mk_seg(SEG_PULSE, PIN_LAT, 1'b0, CNT_W'(4), 1'b0);
                    3'd2:    s = set_seg(PIN_LAT, 1'b0, 1'b0);
                    3'd3:    s = mk_seg(SEG_SHIFT, PIN_DATA, 1'b0, bb, 1'b0);
                    3'd4:    s = set_seg(PIN_CLK, 1'b0, 1'b0);
                    3'd5:    s = set_seg(PIN_LAT, 1'b1, 1'b0);
                    default: s = set_seg(PIN_LAT, 1'b0, 1'b1);
                endcase
            end
            OP_INT: begin
                unique case (idx)
                    3'd0:    s = set_seg(PIN_CLK, 1'b1, 1'b0);
                    3'd1:    s = mk_seg(SEG_PULSE, PIN_LAT, 1'b0, CNT_W'(4), 1'b0);
                    3'd2:    s = mk_seg(SEG_PULSE, PIN_CLK, 1'b0, CNT_W'(3), 1'b0);
                    3'd3:    s = set_seg(PIN_CLK, 1'b0, 1'b0);
                    default: s = set_seg(PIN_LAT, 1'b0, 1'b1);
                endcase
            end
            OP_EXT: begin
                unique case (idx)
                    3'd0:    s = set_seg(PIN_CLK, 1'b1, 1'b0);
                    3'd1:    s = mk_seg(SEG_PULSE, PIN_LAT, 1'b0, CNT_W'(3), 1'b0);
                    3'd2:    s = mk_seg(SEG_PULSE, PIN_CLK, 1'b0, CNT_W'(2), 1'b0);
                    3'd3:    s = set_seg(PIN_CLK, 1'b0, 1'b0);
                    default: s = set_seg(PIN_LAT, 1'b0, 1'b1);
                endcase
            end
            default: s = set_seg(PIN_CLK, 1'b0, 1'b1);
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ledseq_ifs.sv =====
`default_nettype none

// Command channel: one transfer per command.
interface ledseq_in_if;
    import ledseq_pkg::*;
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic               channel;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output op, output channel, output value, input ready);
    modport sink   (input valid, input op, input channel, input value, output ready);
endinterface

// Pin step channel: one transfer per pin write.
interface ledseq_out_if;
    logic valid;
    logic ready;
    logic out_channel;
    logic clk_level;
    logic data_level;
    logic latch_level;
    logic last_step;

    modport source (output valid, output out_channel, output clk_level, output data_level,
                    output latch_level, output last_step, input ready);
    modport sink   (input valid, input out_channel, input clk_level, input data_level,
                    input latch_level, input last_step, output ready);
endinterface

`default_nettype wire

// ===== rtl/ledseq_ctrl.sv =====
`default_nettype none

module ledseq_ctrl
    import ledseq_pkg::*;
#(
    parameter int GRAY_BITS   = GRAY_BITS_DEF,
    parameter int BRIGHT_BITS = BRIGHT_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    ledseq_in_if.sink       i_cmd,
    output t_step           o_step,
    output logic            o_step_valid,
    input  wire logic       i_step_ready
);

    localparam int WORD_W = (GRAY_BITS > BRIGHT_BITS) ? GRAY_BITS : BRIGHT_BITS;
    localparam logic [VALUE_W:0] GRAY_MAX = ((VALUE_W+1)'(1) << GRAY_BITS) - (VALUE_W+1)'(1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    t_state             r_state, n_state;
    logic [SEG_W-1:0]   r_seg, n_seg;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [1:0]         r_sub, n_sub;
    logic [OP_W-1:0]    r_op, n_op;
    logic               r_ch, n_ch;
    logic [WORD_W-1:0]  r_word, n_word;

    t_seg               seg;
    logic               accept;
    logic               op_ok;
    logic               fire;
    logic               unit_end;
    logic               seg_end;
    logic [PIN_W-1:0]   step_pin;
    logic               step_level;
    logic [VALUE_W-1:0] gray_sat;
    logic [WORD_W-1:0]  load_word;

    // Current program segment.
    assign seg = ledseq_seg(r_op, r_seg, GRAY_BITS, BRIGHT_BITS);

    assign i_cmd.ready = (r_state == ST_IDLE);
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign op_ok       = (i_cmd.op <= OP_EXT);
    assign fire        = (r_state == ST_RUN) && i_step_ready;

    // Saturate the grayscale word and align the shift word to its top bit.
    assign gray_sat = ({1'b0, i_cmd.value} > GRAY_MAX) ? GRAY_MAX[VALUE_W-1:0] : i_cmd.value;
    always_comb begin
        if (i_cmd.op == OP_GRAY) begin
            load_word = WORD_W'(gray_sat[GRAY_BITS-1:0]) << (WORD_W - GRAY_BITS);
        end else begin
            load_word = WORD_W'(i_cmd.value[BRIGHT_BITS-1:0]) << (WORD_W - BRIGHT_BITS);
        end
    end

    // Pin and level of the step in progress, and where the unit and segment end.
    always_comb begin
        step_pin   = seg.pin;
        step_level = seg.level;
        unit_end   = 1'b1;
        unique case (seg.kind)
            SEG_SET: begin
                unit_end = 1'b1;
            end
            SEG_PULSE: begin
                step_level = r_sub[0];
                unit_end   = (r_sub == 2'd1);
            end
            SEG_SHIFT: begin
                unit_end = (r_sub == 2'd2);
                unique case (r_sub)
                    2'd0: begin
                        step_pin   = PIN_CLK;
                        step_level = 1'b0;
                    end
                    2'd1: begin
                        step_pin   = PIN_DATA;
                        step_level = r_word[WORD_W-1];
                    end
                    default: begin
                        step_pin   = PIN_CLK;
                        step_level = 1'b1;
                    end
                endcase
            end
            default: begin
                unit_end = 1'b1;
            end
        endcase
    end

    assign seg_end = unit_end && (r_cnt == seg.count - CNT_W'(1));

    assign o_step_valid = (r_state == ST_RUN);
    assign o_step.ch    = r_ch;
    assign o_step.pin   = step_pin;
    assign o_step.level = step_level;
    assign o_step.last  = seg.last && seg_end;

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        n_seg   = r_seg;
        n_cnt   = r_cnt;
        n_sub   = r_sub;
        n_op    = r_op;
        n_ch    = r_ch;
        n_word  = r_word;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && op_ok) begin
                    n_state = ST_RUN;
                    n_seg   = '0;
                    n_cnt   = '0;
                    n_sub   = '0;
                    n_op    = i_cmd.op;
                    n_ch    = i_cmd.channel;
                    n_word  = load_word;
                end
            end
            ST_RUN: begin
                if (fire) begin
                    if ((seg.kind == SEG_SHIFT) && unit_end) begin
                        n_word = r_word << 1;
                    end
                    if (unit_end) begin
                        n_sub = '0;
                        if (seg_end) begin
                            n_cnt = '0;
                            if (seg.last) begin
                                n_state = ST_IDLE;
                            end else begin
                                n_seg = r_seg + SEG_W'(1);
                            end
                        end else begin
                            n_cnt = r_cnt + CNT_W'(1);
                        end
                    end else begin
                        n_sub = r_sub + 2'd1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_seg   <= '0;
            r_cnt   <= '0;
            r_sub   <= '0;
        end else begin
            r_state <= n_state;
            r_seg   <= n_seg;
            r_cnt   <= n_cnt;
            r_sub   <= n_sub;
        end
    end

    // Command payload registers.
    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_ch   <= n_ch;
        r_word <= n_word;
    end

endmodule

`default_nettype wire

// ===== rtl/ledseq_pins.sv =====
`default_nettype none

module ledseq_pins
    import ledseq_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_step  i_step,
    input  wire logic   i_step_valid,
    output logic        o_step_ready,
    ledseq_out_if.source o_pin
);

    logic [2:0] r_lv [2];
    logic       r_valid;
    logic       r_ch;
    logic [2:0] r_out_lv;
    logic       r_last;

    logic [2:0] n_lv;
    logic       take;

    // The output register is free when empty or being drained this cycle.
    assign o_step_ready = !r_valid || o_pin.ready;
    assign take         = i_step_valid && o_step_ready;

    // New pin levels of the addressed chain.
    always_comb begin
        n_lv               = r_lv[i_step.ch];
        n_lv[i_step.pin]   = i_step.level;
    end

    // Per-chain pin state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lv[0] <= '0;
            r_lv[1] <= '0;
            r_valid <= 1'b0;
        end else begin
            if (take) begin
                r_lv[i_step.ch] <= n_lv;
            end
            if (take) begin
                r_valid <= 1'b1;
            end else if (o_pin.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_ch     <= i_step.ch;
            r_out_lv <= n_lv;
            r_last   <= i_step.last;
        end
    end

    assign o_pin.valid       = r_valid;
    assign o_pin.out_channel = r_ch;
    assign o_pin.clk_level   = r_out_lv[PIN_CLK];
    assign o_pin.data_level  = r_out_lv[PIN_DATA];
    assign o_pin.latch_level = r_out_lv[PIN_LAT];
    assign o_pin.last_step   = r_last;

endmodule

`default_nettype wire

// ===== rtl/led_driver_serial_sequencer_core.sv =====
// The first pin step of a command is formed from the registered sequencer state and is
// then held in the pin output register. Throughput: one pin step per cycle while the sink
// takes them; a command occupies the sequencer until its last pin step is taken, and no new
// command is accepted before then, as the single step counter and shift register are shared.
// Undefined command codes are accepted and produce no steps.
// Reset: synchronous, active low; all pins of both chains go low and no step is pending.
`default_nettype none

module led_driver_serial_sequencer_core
    import ledseq_pkg::*;
#(
    parameter int GRAY_BITS   = GRAY_BITS_DEF,
    parameter int BRIGHT_BITS = BRIGHT_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    ledseq_in_if.sink       i_cmd,
    ledseq_out_if.source    o_step
);

    t_step step;
    logic  step_valid;
    logic  step_ready;

    // Command sequencer.
    ledseq_ctrl #(
        .GRAY_BITS   (GRAY_BITS),
        .BRIGHT_BITS (BRIGHT_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (i_cmd),
        .o_step       (step),
        .o_step_valid (step_valid),
        .i_step_ready (step_ready)
    );

    // Pin state and output register.
    ledseq_pins u_pins (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_step_valid (step_valid),
        .o_step_ready (step_ready),
        .o_pin        (o_step)
    );

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import ledseq_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 10;
    localparam int RANDOM_ITEMS   = 92;
    localparam int DRAIN_CYCLES   = 10;
    localparam int LIMIT_CYCLES   = 500000;
    localparam int GRAY_BITS      = GRAY_BITS_DEF;
    localparam int BRIGHT_BITS    = BRIGHT_BITS_DEF;

    localparam logic [VALUE_W-1:0] GRAY_MAX    = VALUE_W'((1 << GRAY_BITS) - 1);
    localparam logic [VALUE_W-1:0] BRIGHT_MASK = VALUE_W'((1 << BRIGHT_BITS) - 1);

    // Command codes the block must drop without any pin activity.
    localparam logic [OP_W-1:0] OP_UNUSED_FIRST = OP_EXT + 3'd1;
    localparam logic [OP_W-1:0] OP_UNUSED_LAST  = '1;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic               ch;
        logic [VALUE_W-1:0] value;
    } led_cmd_t;

    typedef struct packed {
        logic ch;
        logic clk;
        logic data;
        logic lat;
        logic last;
    } pin_step_t;

    logic i_clk;
    logic i_rst_n;

    ledseq_in_if  cmd_if ();
    ledseq_out_if step_if ();

    led_driver_serial_sequencer_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_step  (step_if)
    );

    // Commands waiting to be driven and pin steps waiting to be seen.
    led_cmd_t  cmd_backlog[$];
    pin_step_t pin_step_q[$];
    logic [2:0] chain_pins [2];

    int  total_cmds;
    int  issued_cnt;
    int  cmds_taken;
    int  ignored_taken;
    int  steps_checked;
    int  fault_cnt;
    int  cycle_cnt;
    int  op_seen [8];
    bit  cmd_accepted;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Pin model: one expected step per pin write, the level of all three pins after it.
    function automatic void drive_pin(input logic ch, input logic [PIN_W-1:0] pin,
                                      input logic level, input logic last);
        pin_step_t s;
        chain_pins[ch][pin] = level;
        s.ch   = ch;
        s.clk  = chain_pins[ch][PIN_CLK];
        s.data = chain_pins[ch][PIN_DATA];
        s.lat  = chain_pins[ch][PIN_LAT];
        s.last = last;
        pin_step_q.push_back(s);
    endfunction

    // Serial shift, MSB first: clock low, data bit, clock high.
    function automatic void shift_word(input logic ch, input logic [VALUE_W-1:0] word,
                                       input int nbits);
        for (int i = nbits - 1; i >= 0; i--) begin
            drive_pin(ch, PIN_CLK, 1'b0, 1'b0);
            drive_pin(ch, PIN_DATA, word[i], 1'b0);
            drive_pin(ch, PIN_CLK, 1'b1, 1'b0);
        end
    endfunction

    function automatic void pulse_pin(input logic ch, input logic [PIN_W-1:0] pin, input int n);
        for (int i = 0; i < n; i++) begin
            drive_pin(ch, pin, 1'b0, 1'b0);
            drive_pin(ch, pin, 1'b1, 1'b0);
        end
    endfunction

    // Expands one accepted command into the pin steps it must produce.
    function automatic void expand_command(input led_cmd_t c);
        logic [VALUE_W-1:0] word;
        case (c.op)
            OP_GRAY: begin
                word = (c.value > GRAY_MAX) ? GRAY_MAX : c.value;
                shift_word(c.ch, word, GRAY_BITS);
                drive_pin(c.ch, PIN_CLK, 1'b0, 1'b0);
                drive_pin(c.ch, PIN_DATA, 1'b0, 1'b1);
            end
            OP_LATCH: begin
                drive_pin(c.ch, PIN_CLK, 1'b0, 1'b0);
                drive_pin(c.ch, PIN_LAT, 1'b1, 1'b0);
                drive_pin(c.ch, PIN_LAT, 1'b0, 1'b1);
            end
            OP_BRIGHT: begin
                word = c.value & BRIGHT_MASK;
                drive_pin(c.ch, PIN_CLK, 1'b1, 1'b0);
                pulse_pin(c.ch, PIN_LAT, 4);
                drive_pin(c.ch, PIN_LAT, 1'b0, 1'b0);
                shift_word(c.ch, word, BRIGHT_BITS);
                drive_pin(c.ch, PIN_CLK, 1'b0, 1'b0);
                drive_pin(c.ch, PIN_LAT, 1'b1, 1'b0);
                drive_pin(c.ch, PIN_LAT, 1'b0, 1'b1);
            end
            OP_INT: begin
                drive_pin(c.ch, PIN_CLK, 1'b1, 1'b0);
                pulse_pin(c.ch, PIN_LAT, 4);
                pulse_pin(c.ch, PIN_CLK, 3);
                drive_pin(c.ch, PIN_CLK, 1'b0, 1'b0);
                drive_pin(c.ch, PIN_LAT, 1'b0, 1'b1);
            end
            OP_EXT: begin
                drive_pin(c.ch, PIN_CLK, 1'b1, 1'b0);
                pulse_pin(c.ch, PIN_LAT, 3);
                pulse_pin(c.ch, PIN_CLK, 2);
                drive_pin(c.ch, PIN_CLK, 1'b0, 1'b0);
                drive_pin(c.ch, PIN_LAT, 1'b0, 1'b1);
            end
            default: begin
                // Unused codes leave the pins alone.
            end
        endcase
    endfunction

    // Idle percentage for the sender or receiver, by quarter of the command stream.
    function automatic int idle_pct(input bit receiver);
        int phase;
        phase = (total_cmds == 0) ? 0 : (issued_cnt * 4) / total_cmds;
        case (phase)
            0:       return 0;
            1:       return receiver ? 0 : 65;
            2:       return receiver ? 65 : 0;
            default: return 23;
        endcase
    endfunction

    task automatic add_cmd(input logic [OP_W-1:0] op, input logic ch,
                           input logic [VALUE_W-1:0] value);
        led_cmd_t c;
        c.op    = op;
        c.ch    = ch;
        c.value = value;
        cmd_backlog.push_back(c);
    endtask

    // Driver: presents commands and drives the step ready, all on the falling edge.
    always @(negedge i_clk) begin : cmd_driver
        led_cmd_t c;
        if (i_rst_n) begin
            if (!cmd_if.valid || cmd_accepted) begin
                cmd_accepted = 1'b0;
                if (cmd_backlog.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
                    c = cmd_backlog.pop_front();
                    cmd_if.valid   <= 1'b1;
                    cmd_if.op      <= c.op;
                    cmd_if.channel <= c.ch;
                    cmd_if.value   <= c.value;
                    issued_cnt++;
                end else begin
                    cmd_if.valid <= 1'b0;
                end
            end
            step_if.ready <= ($urandom_range(99) >= idle_pct(1'b1));
        end
    end

    // Monitor: checks pin steps, then predicts for a command accepted at this edge.
    always @(posedge i_clk) begin : step_monitor
        pin_step_t want;
        if (i_rst_n) begin
            if (step_if.valid && step_if.ready) begin
                if (pin_step_q.size() == 0) begin
                    $display("%0t: unexpected pin step ch=%0d clk=%0d data=%0d lat=%0d last=%0d",
                             $time, step_if.out_channel, step_if.clk_level,
                             step_if.data_level, step_if.latch_level, step_if.last_step);
                    fault_cnt++;
                end else begin
                    want = pin_step_q.pop_front();
                    steps_checked++;
                    if (step_if.out_channel !== want.ch || step_if.clk_level !== want.clk ||
                        step_if.data_level !== want.data || step_if.latch_level !== want.lat ||
                        step_if.last_step !== want.last) begin
                        $display("%0t: step mismatch: expected ch=%0d clk=%0d data=%0d lat=%0d last=%0d",
                                 $time, want.ch, want.clk, want.data, want.lat, want.last);
                        $display("%0t: step mismatch: got ch=%0d clk=%0d data=%0d lat=%0d last=%0d",
                                 $time, step_if.out_channel, step_if.clk_level,
                                 step_if.data_level, step_if.latch_level, step_if.last_step);
                        fault_cnt++;
                    end
                end
            end
            if (cmd_if.valid && cmd_if.ready) begin
                cmd_accepted = 1'b1;
                cmds_taken++;
                op_seen[cmd_if.op]++;
                if (cmd_if.op > OP_EXT)
                    ignored_taken++;
                expand_command('{cmd_if.op, cmd_if.channel, cmd_if.value});
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("%0t: timeout with %0d pin steps outstanding", $time, pin_step_q.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial begin : stimulus
        int sel;
        int rand_cnt;
        logic [VALUE_W-1:0] v;

        cmd_if.valid   = 1'b0;
        cmd_if.op      = OP_GRAY;
        cmd_if.channel = 1'b0;
        cmd_if.value   = '0;
        step_if.ready  = 1'b0;
        i_rst_n        = 1'b0;
        chain_pins[0]  = 3'b000;
        chain_pins[1]  = 3'b000;
        cmd_accepted   = 1'b0;
        issued_cnt     = 0;
        cmds_taken     = 0;
        ignored_taken  = 0;
        steps_checked  = 0;
        fault_cnt      = 0;
        cycle_cnt      = 0;
        foreach (op_seen[i]) op_seen[i] = 0;

        // Directed: grayscale extremes and clamping, every command on both chains,
        // brightness with high bits set, and the unused codes.
        add_cmd(OP_GRAY, 1'b0, 16'h0000);
        add_cmd(OP_GRAY, 1'b1, GRAY_MAX);
        add_cmd(OP_GRAY, 1'b0, GRAY_MAX + 16'd1);
        add_cmd(OP_GRAY, 1'b1, 16'hFFFF);
        add_cmd(OP_UNUSED_FIRST, 1'b0, 16'hFFFF);
        add_cmd(OP_GRAY, 1'b0, 16'h0800);
        add_cmd(OP_GRAY, 1'b1, 16'h0AAA);
        add_cmd(OP_GRAY, 1'b0, 16'h0555);
        add_cmd(OP_LATCH, 1'b0, 16'h0000);
        add_cmd(OP_LATCH, 1'b1, 16'hFFFF);
        add_cmd(OP_BRIGHT, 1'b0, 16'h0000);
        add_cmd(OP_BRIGHT, 1'b1, 16'h00FF);
        add_cmd(OP_UNUSED_FIRST + 3'd1, 1'b1, 16'h1234);
        add_cmd(OP_BRIGHT, 1'b0, 16'hFF00);
        add_cmd(OP_BRIGHT, 1'b1, 16'h005A);
        add_cmd(OP_BRIGHT, 1'b0, 16'hFFA5);
        add_cmd(OP_INT, 1'b0, 16'h0000);
        add_cmd(OP_INT, 1'b1, 16'hFFFF);
        add_cmd(OP_EXT, 1'b1, 16'h0000);
        add_cmd(OP_EXT, 1'b0, 16'hFFFF);
        add_cmd(OP_UNUSED_LAST, 1'b0, 16'h0000);
        add_cmd(OP_LATCH, 1'b1, 16'h0000);

        // Random: mostly real commands with random content, a few unused codes.
        rand_cnt = 0;
        while (rand_cnt < RANDOM_ITEMS) begin
            sel = $urandom_range(99);
            v   = VALUE_W'($urandom());
            if (sel < 6) begin
                add_cmd(OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)),
                        1'($urandom_range(1)), v);
            end else begin
                rand_cnt++;
                if (sel < 45) begin
                    case ($urandom_range(3))
                        0:       v = VALUE_W'($urandom_range(0, GRAY_MAX));
                        1:       v = VALUE_W'($urandom_range(GRAY_MAX - 2, GRAY_MAX + 2));
                        default: ;
                    endcase
                    add_cmd(OP_GRAY, 1'($urandom_range(1)), v);
                end else if (sel < 65) begin
                    add_cmd(OP_BRIGHT, 1'($urandom_range(1)), v);
                end else if (sel < 80) begin
                    add_cmd(OP_LATCH, 1'($urandom_range(1)), v);
                end else if (sel < 90) begin
                    add_cmd(OP_INT, 1'($urandom_range(1)), v);
                end else begin
                    add_cmd(OP_EXT, 1'($urandom_range(1)), v);
                end
            end
        end
        total_cmds = cmd_backlog.size();

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Wait until every command is taken and every pin step has come out.
        while (cmd_backlog.size() != 0 || cmd_if.valid) @(posedge i_clk);
        while (pin_step_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d commands (%0d with unused codes) on both chains; %0d pin steps checked.",
                 cmds_taken, ignored_taken, steps_checked);
        $display("By kind: grayscale %0d, latch %0d, brightness %0d, internal %0d, external %0d.",
                 op_seen[OP_GRAY], op_seen[OP_LATCH], op_seen[OP_BRIGHT],
                 op_seen[OP_INT], op_seen[OP_EXT]);
        if (fault_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
